>>> src/assert_macros.svh
// assertion macros shared by the lexer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock once out of reset
`define LEX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked also during reset
`define LEX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error("assertion failed");

`endif

>>> src/lex_pkg.sv
// types, constants and helpers of the token lexer
`default_nettype none
package lex_pkg;
    localparam int LEN_BITS = 16;
    localparam int VAL_W = 63;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    localparam logic [7:0] C_US = 8'h5f;
    localparam logic [7:0] C_DQ = 8'h22;
    localparam logic [7:0] C_BS = 8'h5c;
    localparam logic [7:0] C_SQ = 8'h27;
    localparam logic [7:0] C_NL = 8'h0a;
    localparam logic [7:0] C_CR = 8'h0d;
    localparam logic [7:0] C_TAB = 8'h09;
    localparam logic [7:0] C_ZERO = 8'h30;
    localparam logic [7:0] C_SP = 8'h20;

    typedef enum logic [3:0] {
        K_IDENT, K_STRING, K_CHAR, K_NUMBER, K_PLUS, K_MINUS, K_MUL,
        K_DIV, K_MOD, K_EQUAL, K_SEMI, K_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE, E_BAD_BYTE, E_UNTERM_STR, E_UNTERM_CHAR, E_CHAR_LONG,
        E_CHAR_EMPTY, E_BAD_ESC
    } err_t;

    typedef struct packed {
        kind_t            kind;
        logic [VAL_W-1:0] value;
        logic             token_end;
        err_t             err_code;
    } result_t;

    // results caused by one byte, item[0] first
    typedef struct packed {
        logic [1:0]        cnt;
        result_t [2:0]     item;
    } bundle_t;

    function automatic result_t mk(kind_t k, logic [VAL_W-1:0] v, logic e, err_t c);
        result_t r;
        r.kind = k;
        r.value = v;
        r.token_end = e;
        r.err_code = c;
        return r;
    endfunction

    function automatic bundle_t push(bundle_t b, result_t r);
        bundle_t o;
        o = b;
        if (b.cnt != 2'd3) begin
            o.item[b.cnt] = r;
            o.cnt = b.cnt + 2'd1;
        end
        return o;
    endfunction
endpackage
`default_nettype wire

>>> src/lex_front.sv
// front end: per-byte lexer state machine, builds result bundles
`default_nettype none
module lex_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic [7:0]      ch,
    input  wire logic            line_end,
    input  wire logic            accept,
    output lex_pkg::bundle_t     bundle,
    output logic                 push_valid
);
    import lex_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_NUM, M_STR, M_CH_OPEN, M_CH_ONE, M_CH_ESC,
        M_CH_ESC_ONE, M_SKIP
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [VAL_W-1:0]    acc_reg, acc_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic                esc_reg, esc_next;
    logic [7:0]          h0_reg, h0_next, h1_reg, h1_next;

    logic                is_alpha, is_digit;
    logic [3:0]          dig;
    logic [VAL_W+3:0]    mul_sum;
    logic [VAL_W-1:0]    acc_step;

    assign is_alpha = (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a)
                      || ch == C_US;
    assign is_digit = ch >= C_ZERO && ch <= 8'h39;
    assign dig = ch[3:0];
    // acc*10 + digit as shift-add, saturate at all ones
    assign mul_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {{VAL_W{1'b0}}, dig};
    assign acc_step = (mul_sum > {4'b0000, VAL_MAX}) ? VAL_MAX : mul_sum[VAL_W-1:0];

    function automatic logic [LEN_BITS-1:0] inc_len(logic [LEN_BITS-1:0] v);
        return (v == LEN_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] ext8(logic [7:0] v);
        return {{(VAL_W-8){1'b0}}, v};
    endfunction

    function automatic logic [VAL_W-1:0] extl(logic [LEN_BITS-1:0] v);
        return {{(VAL_W-LEN_BITS){1'b0}}, v};
    endfunction

    always_comb begin
        bundle_t b;
        logic    done;
        logic    clr;
        logic [7:0] ev;
        b = '0;
        done = 1'b1;
        clr = 1'b0;
        ev = 8'h00;
        mode_next = mode_reg;
        acc_next = acc_reg;
        len_next = len_reg;
        esc_next = esc_reg;
        h0_next = h0_reg;
        h1_next = h1_reg;
        case (mode_reg)
            M_IDENT: begin
                if (is_alpha || is_digit) begin
                    b = push(b, mk(K_IDENT, ext8(ch), 1'b0, E_NONE));
                    len_next = inc_len(len_reg);
                end else begin
                    b = push(b, mk(K_IDENT, extl(len_reg), 1'b1, E_NONE));
                    clr = 1'b1;
                    mode_next = M_IDLE;
                    done = 1'b0;
                end
            end
            M_NUM: begin
                if (is_digit) begin
                    acc_next = acc_step;
                end else begin
                    b = push(b, mk(K_NUMBER, acc_reg, 1'b1, E_NONE));
                    clr = 1'b1;
                    mode_next = M_IDLE;
                    done = 1'b0;
                end
            end
            M_STR: begin
                if (esc_reg) begin
                    esc_next = 1'b0;
                    if (ch == 8'h6e || ch == 8'h72 || ch == 8'h74) begin
                        ev = (ch == 8'h6e) ? C_NL : (ch == 8'h72) ? C_CR : C_TAB;
                        b = push(b, mk(K_STRING, ext8(ev), 1'b0, E_NONE));
                        len_next = inc_len(len_reg);
                    end else begin
                        b = push(b, mk(K_STRING, ext8(C_BS), 1'b0, E_NONE));
                        b = push(b, mk(K_STRING, ext8(ch), 1'b0, E_NONE));
                        len_next = inc_len(inc_len(len_reg));
                    end
                end else if (ch == C_BS) begin
                    esc_next = 1'b1;
                end else if (ch == C_DQ) begin
                    b = push(b, mk(K_STRING, extl(len_reg), 1'b1, E_NONE));
                    clr = 1'b1;
                    mode_next = M_IDLE;
                end else begin
                    b = push(b, mk(K_STRING, ext8(ch), 1'b0, E_NONE));
                    len_next = inc_len(len_reg);
                end
            end
            M_CH_OPEN: begin
                if (ch == C_BS) begin
                    mode_next = M_CH_ESC;
                end else begin
                    h0_next = ch;
                    mode_next = M_CH_ONE;
                end
            end
            M_CH_ONE: begin
                if (ch != C_SQ) begin
                    b = push(b, mk(K_ERROR, '0, 1'b1, E_CHAR_LONG));
                    clr = 1'b1;
                    mode_next = M_SKIP;
                end else if (h0_reg == C_SQ) begin
                    b = push(b, mk(K_ERROR, '0, 1'b1, E_CHAR_EMPTY));
                    clr = 1'b1;
                    mode_next = M_SKIP;
                end else begin
                    b = push(b, mk(K_CHAR, ext8(h0_reg), 1'b1, E_NONE));
                    clr = 1'b1;
                    mode_next = M_IDLE;
                end
            end
            M_CH_ESC: begin
                h1_next = ch;
                mode_next = M_CH_ESC_ONE;
            end
            M_CH_ESC_ONE: begin
                clr = 1'b1;
                if (ch != C_SQ) begin
                    b = push(b, mk(K_ERROR, '0, 1'b1, E_CHAR_LONG));
                    mode_next = M_SKIP;
                end else if (h1_reg == 8'h6e || h1_reg == 8'h72 || h1_reg == 8'h74
                             || h1_reg == C_BS || h1_reg == C_SQ || h1_reg == C_ZERO) begin
                    ev = (h1_reg == 8'h6e) ? C_NL : (h1_reg == 8'h72) ? C_CR :
                         (h1_reg == 8'h74) ? C_TAB : (h1_reg == C_ZERO) ? 8'h00 : h1_reg;
                    b = push(b, mk(K_CHAR, ext8(ev), 1'b1, E_NONE));
                    mode_next = M_IDLE;
                end else begin
                    b = push(b, mk(K_ERROR, ext8(h1_reg), 1'b1, E_BAD_ESC));
                    mode_next = M_SKIP;
                end
            end
            M_SKIP: begin
            end
            default: begin
                mode_next = M_IDLE;
                done = 1'b0;
            end
        endcase
        if (clr) begin
            acc_next = '0;
            len_next = '0;
            esc_next = 1'b0;
            h0_next = 8'h00;
            h1_next = 8'h00;
        end
        // start a fresh token with this byte
        if (!done && !(ch == C_SP || ch == C_NL || ch == C_TAB)) begin
            if (is_alpha) begin
                b = push(b, mk(K_IDENT, ext8(ch), 1'b0, E_NONE));
                len_next = {{(LEN_BITS-1){1'b0}}, 1'b1};
                mode_next = M_IDENT;
            end else if (is_digit) begin
                acc_next = {{(VAL_W-4){1'b0}}, dig};
                mode_next = M_NUM;
            end else if (ch == C_DQ) begin
                len_next = '0;
                esc_next = 1'b0;
                mode_next = M_STR;
            end else if (ch == C_SQ) begin
                mode_next = M_CH_OPEN;
            end else if (ch == 8'h2b) begin
                b = push(b, mk(K_PLUS, '0, 1'b1, E_NONE));
            end else if (ch == 8'h2d) begin
                b = push(b, mk(K_MINUS, '0, 1'b1, E_NONE));
            end else if (ch == 8'h2a) begin
                b = push(b, mk(K_MUL, '0, 1'b1, E_NONE));
            end else if (ch == 8'h2f) begin
                b = push(b, mk(K_DIV, '0, 1'b1, E_NONE));
            end else if (ch == 8'h25) begin
                b = push(b, mk(K_MOD, '0, 1'b1, E_NONE));
            end else if (ch == 8'h3d) begin
                b = push(b, mk(K_EQUAL, '0, 1'b1, E_NONE));
            end else if (ch == 8'h3b) begin
                b = push(b, mk(K_SEMI, '0, 1'b1, E_NONE));
            end else begin
                b = push(b, mk(K_ERROR, ext8(ch), 1'b1, E_BAD_BYTE));
                acc_next = '0;
                len_next = '0;
                esc_next = 1'b0;
                h0_next = 8'h00;
                h1_next = 8'h00;
                mode_next = M_SKIP;
            end
        end
        // end of line closes or fails whatever is open
        if (line_end) begin
            if (mode_next == M_IDENT) begin
                b = push(b, mk(K_IDENT, extl(len_next), 1'b1, E_NONE));
            end else if (mode_next == M_NUM) begin
                b = push(b, mk(K_NUMBER, acc_next, 1'b1, E_NONE));
            end else if (mode_next == M_STR) begin
                b = push(b, mk(K_ERROR, '0, 1'b1, E_UNTERM_STR));
            end else if (mode_next == M_CH_OPEN || mode_next == M_CH_ONE
                         || mode_next == M_CH_ESC || mode_next == M_CH_ESC_ONE) begin
                b = push(b, mk(K_ERROR, '0, 1'b1, E_UNTERM_CHAR));
            end
            acc_next = '0;
            len_next = '0;
            esc_next = 1'b0;
            h0_next = 8'h00;
            h1_next = 8'h00;
            mode_next = M_IDLE;
        end
        bundle = b;
    end

    assign push_valid = accept && (bundle.cnt != 2'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            acc_reg <= '0;
            len_reg <= '0;
            esc_reg <= 1'b0;
            h0_reg <= 8'h00;
            h1_reg <= 8'h00;
        end else if (accept) begin
            mode_reg <= mode_next;
            acc_reg <= acc_next;
            len_reg <= len_next;
            esc_reg <= esc_next;
            h0_reg <= h0_next;
            h1_reg <= h1_next;
        end
    end
endmodule
`default_nettype wire

>>> src/lex_queue.sv
// short queue of result bundles between front and back
`default_nettype none
module lex_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire lex_pkg::bundle_t wr_data,
    input  wire logic             pop,
    output lex_pkg::bundle_t      rd_data,
    output logic                  full,
    output logic                  empty
);
    import lex_pkg::*;

    bundle_t           mem [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full = cnt_reg == QDEPTH[QPTR_W:0];
    assign empty = cnt_reg == '0;
    assign rd_data = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

>>> src/lex_back.sv
// back end: sends the results of each bundle one beat at a time
`default_nettype none
module lex_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire lex_pkg::bundle_t rd_data,
    input  wire logic             empty,
    output logic                  pop,
    output lex_pkg::result_t      res,
    output logic                  res_last,
    output logic                  res_valid,
    input  wire logic             res_ready
);
    import lex_pkg::*;

    bundle_t    cur_reg;
    logic       valid_reg;
    logic [1:0] idx_reg;
    logic       fin;

    assign res = cur_reg.item[idx_reg];
    assign res_last = idx_reg == (cur_reg.cnt - 2'd1);
    assign res_valid = valid_reg;
    assign fin = valid_reg && res_ready && res_last;
    assign pop = !empty && (!valid_reg || fin);

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= rd_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg <= 2'd0;
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                idx_reg <= 2'd0;
            end else if (fin) begin
                valid_reg <= 1'b0;
                idx_reg <= 2'd0;
            end else if (valid_reg && res_ready) begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end
endmodule
`default_nettype wire

>>> src/c_like_token_lexer.sv
// streaming lexer for a small c-like language, top level
//
// input stream: one source byte per beat on s_tdata, s_tlast marks the
// final byte of a line (pending tokens close, open literals fail there).
// output stream: one result per beat; m_tuser is the token kind,
// m_tdata carries value, token end flag and error code, m_tlast marks the
// last result caused by one input byte.
// a byte is taken every cycle while the four-entry bundle queue has room.
// a byte that causes results passes them through the bundle queue and then
// the back end's current-bundle register to the output; its results go out
// one per beat, so the sustained rate is one byte per cycle while bytes
// average at most one result and m_tready stays high, set by the one-result-per-beat stage.
// bytes that cause no result (whitespace between tokens, digits of a number,
// literal openers) only update the lexer state.
// while m_tready is low the queue fills, then s_tready drops; nothing is
// lost. reset (aresetn low, synchronous) empties the queue and returns
// the lexer to its between-tokens state.
`default_nettype none
module c_like_token_lexer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // ch
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // value, token_end, err_code, zero pad
    output logic [3:0]       m_tuser,   // kind
    output logic             m_tlast
);
    import lex_pkg::*;
    `include "assert_macros.svh"

    bundle_t bundle, rd_data;
    result_t res;
    logic    accept, push_valid, pop, full, empty;

    assign s_tready = !full;
    assign accept = s_tvalid && s_tready;

    lex_front u_front (
        .aclk(aclk), .aresetn(aresetn), .ch(s_tdata), .line_end(s_tlast),
        .accept(accept), .bundle(bundle), .push_valid(push_valid)
    );

    lex_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(push_valid), .wr_data(bundle),
        .pop(pop), .rd_data(rd_data), .full(full), .empty(empty)
    );

    lex_back u_back (
        .aclk(aclk), .aresetn(aresetn), .rd_data(rd_data), .empty(empty),
        .pop(pop), .res(res), .res_last(m_tlast), .res_valid(m_tvalid),
        .res_ready(m_tready)
    );

    assign m_tuser = res.kind;
    assign m_tdata = {5'b00000, res.err_code, res.token_end, res.value};

    `LEX_ASSERT_IMP(a_err_closes, m_tvalid && m_tuser == K_ERROR, m_tdata[63])
    `LEX_ASSERT_IMP(a_err_code_kind, m_tvalid, (m_tuser == K_ERROR) == (m_tdata[66:64] != 3'd0))
    `LEX_ASSERT_NXT(a_reset_quiet, !aresetn, !m_tvalid)
endmodule
`default_nettype wire
